[src/mtpl_pkg.sv]
// ----------------------------------------------------------------------------
// mtpl_pkg
// Shared types and constants for the multibit trie prefix lookup engine:
// operation codes, state encoding and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mtpl_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned LEAF_BIT = 0;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } mtpl_op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_L1   = 2'd1,
    ST_L2   = 2'd2,
    ST_L3   = 2'd3
  } mtpl_state_e;

  // Source of the table address for the current cycle.
  typedef enum logic [1:0] {
    ASEL_WRITE = 2'd0,
    ASEL_ROOT  = 2'd1,
    ASEL_MID   = 2'd2,
    ASEL_LAST  = 2'd3
  } mtpl_addr_sel_e;

  typedef struct packed {
    logic           rd_en;
    logic           wr_en;
    logic           key_load;
    logic           load_out;
    mtpl_addr_sel_e addr_sel;
  } mtpl_cmd_t;

  typedef struct packed {
    logic leaf;
    logic out_busy;
  } mtpl_sts_t;

endpackage

[src/multibit_trie_prefix_lookup.sv]
// ----------------------------------------------------------------------------
// multibit_trie_prefix_lookup
// Longest-prefix-match engine over a multibit trie held in a single-port
// table of 32-bit words.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                                      Direction  Moves
//  -------  -------------------------------------------  ---------  --------------
//  in       in_valid_i/in_ready_o, op_i, lookup_key_i,   input      lookup or write
//           table_addr_i, table_data_i
//  out      out_valid_o/out_ready_i, leaf_word_o         output     leaf word
//  cfg      cfg_valid_i/cfg_ready_o, root_base_i         input      root base
//
//  A write transaction stores its word in the accept cycle and frees the input
//  at once. A lookup takes one table read per trie level (1 to 3 reads) and
//  then loads the result register; the reads are dependent and share the one
//  table port, so a lookup holds the input until its result is loaded. Reset
//  is asynchronous and active low; it clears the controller, the result valid
//  and root_base, but not the table, whose entries are undefined until
//  written (no clearing pass). A full result register with out_ready_i low
//  holds a finishing lookup in its last state; input is still accepted while
//  the result waits, as long as the engine idles. TABLE_DEPTH must be a power
//  of two (the block does not check it): addresses wrap by truncation.
//
module multibit_trie_prefix_lookup #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned ROOT_BITS   = 4,
  parameter int unsigned MID_BITS    = 3,
  parameter int unsigned LAST_BITS   = 3,
  localparam int unsigned ADDR_W     = $clog2(TABLE_DEPTH),
  localparam int unsigned KEY_W      = ROOT_BITS + MID_BITS + LAST_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ADDR_W-1:0]           root_base_i,
  // input transactions
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [KEY_W-1:0]            lookup_key_i,
  input  logic [ADDR_W-1:0]           table_addr_i,
  input  logic [mtpl_pkg::DATA_W-1:0] table_data_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mtpl_pkg::DATA_W-1:0] leaf_word_o
);

  mtpl_pkg::mtpl_cmd_t cmd;
  mtpl_pkg::mtpl_sts_t sts;

  // Configuration must be written only while idle (the block does not enforce it); take it whenever offered.
  assign cfg_ready_o = 1'b1;

  // Sequence the level reads.
  mtpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the table, the key, the root base and the result register.
  mtpl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ROOT_BITS   (ROOT_BITS),
    .MID_BITS    (MID_BITS),
    .LAST_BITS   (LAST_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .root_base_i  (root_base_i),
    .lookup_key_i (lookup_key_i),
    .table_addr_i (table_addr_i),
    .table_data_i (table_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .leaf_word_o  (leaf_word_o)
  );

endmodule

[src/mtpl_dp.sv]
// ----------------------------------------------------------------------------
// mtpl_dp
// Datapath: root base register, key register, single-port trie table with
// registered read data, address generation and the result register.
// ----------------------------------------------------------------------------
module mtpl_dp #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned ROOT_BITS   = 4,
  parameter int unsigned MID_BITS    = 3,
  parameter int unsigned LAST_BITS   = 3,
  localparam int unsigned ADDR_W     = $clog2(TABLE_DEPTH),
  localparam int unsigned KEY_W      = ROOT_BITS + MID_BITS + LAST_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ADDR_W-1:0]         root_base_i,
  input  logic [KEY_W-1:0]          lookup_key_i,
  input  logic [ADDR_W-1:0]         table_addr_i,
  input  logic [mtpl_pkg::DATA_W-1:0] table_data_i,
  input  mtpl_pkg::mtpl_cmd_t       cmd_i,
  output mtpl_pkg::mtpl_sts_t       sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mtpl_pkg::DATA_W-1:0] leaf_word_o
);

  logic [ADDR_W-1:0]           root_base_q;
  logic [KEY_W-1:0]            key_q;
  logic [mtpl_pkg::DATA_W-1:0] mem_q [TABLE_DEPTH];
  logic [mtpl_pkg::DATA_W-1:0] rdata_q;
  logic [mtpl_pkg::DATA_W-1:0] out_data_q;
  logic                        out_valid_q;
  logic                        out_valid_d;
  logic [ADDR_W-1:0]           addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_base_q <= '0;
    end else if (cfg_we_i) begin
      root_base_q <= root_base_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_load) begin
      key_q <= lookup_key_i;
    end
  end

  // Addresses wrap at the table depth by truncation.
  always_comb begin
    case (cmd_i.addr_sel)
      mtpl_pkg::ASEL_WRITE: addr = table_addr_i;
      mtpl_pkg::ASEL_ROOT:  addr = root_base_q
                                   + ADDR_W'(lookup_key_i[KEY_W-1 -: ROOT_BITS]);
      mtpl_pkg::ASEL_MID:   addr = rdata_q[ADDR_W-1:0]
                                   + ADDR_W'(key_q[LAST_BITS +: MID_BITS]);
      mtpl_pkg::ASEL_LAST:  addr = rdata_q[ADDR_W-1:0]
                                   + ADDR_W'(key_q[LAST_BITS-1:0]);
      default:              addr = table_addr_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[addr] <= table_data_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= rdata_q;
    end
  end

  assign sts_o.leaf     = rdata_q[mtpl_pkg::LEAF_BIT];
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign leaf_word_o    = out_data_q;

endmodule

[src/mtpl_ctrl.sv]
// ----------------------------------------------------------------------------
// mtpl_ctrl
// Controller: sequences the up to three dependent table reads of a lookup
// and the one-cycle write strobe, and hands results to the output register.
// ----------------------------------------------------------------------------
module mtpl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  mtpl_pkg::mtpl_sts_t   sts_i,
  output mtpl_pkg::mtpl_cmd_t   cmd_o
);

  mtpl_pkg::mtpl_state_e state_q;
  mtpl_pkg::mtpl_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtpl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mtpl_pkg::ST_IDLE: begin
        if (in_valid_i && op_i == mtpl_pkg::OP_LOOKUP) begin
          state_d = mtpl_pkg::ST_L1;
        end
      end
      mtpl_pkg::ST_L1: begin
        if (!sts_i.leaf) begin
          state_d = mtpl_pkg::ST_L2;
        end else if (!sts_i.out_busy) begin
          state_d = mtpl_pkg::ST_IDLE;
        end
      end
      mtpl_pkg::ST_L2: begin
        if (!sts_i.leaf) begin
          state_d = mtpl_pkg::ST_L3;
        end else if (!sts_i.out_busy) begin
          state_d = mtpl_pkg::ST_IDLE;
        end
      end
      mtpl_pkg::ST_L3: begin
        if (!sts_i.out_busy) begin
          state_d = mtpl_pkg::ST_IDLE;
        end
      end
      default: state_d = mtpl_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.addr_sel = mtpl_pkg::ASEL_WRITE;
    case (state_q)
      mtpl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (op_i == mtpl_pkg::OP_WRITE) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.rd_en    = 1'b1;
            cmd_o.key_load = 1'b1;
            cmd_o.addr_sel = mtpl_pkg::ASEL_ROOT;
          end
        end
      end
      mtpl_pkg::ST_L1: begin
        if (!sts_i.leaf) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = mtpl_pkg::ASEL_MID;
        end else begin
          cmd_o.load_out = !sts_i.out_busy;
        end
      end
      mtpl_pkg::ST_L2: begin
        if (!sts_i.leaf) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = mtpl_pkg::ASEL_LAST;
        end else begin
          cmd_o.load_out = !sts_i.out_busy;
        end
      end
      mtpl_pkg::ST_L3: begin
        cmd_o.load_out = !sts_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.rd_en && cmd_o.wr_en))
    else $error("table read and write issued in the same cycle");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !sts_i.out_busy)
    else $error("result loaded while output register still full");

  a_lookup_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mtpl_pkg::ST_IDLE && in_valid_i && op_i == mtpl_pkg::OP_LOOKUP)
    |=> state_q == mtpl_pkg::ST_L1)
    else $error("accepted lookup did not start the root read");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mtpl_pkg::ST_L3 && !sts_i.out_busy) |=> state_q == mtpl_pkg::ST_IDLE)
    else $error("third-level result not retired");

endmodule
